@@ hdl/urldec_pkg.sv @@
// Package for the URL percent decoder: result item type, character codes,
// hex digit decode. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package urldec_pkg;

    localparam int MAX_RESULTS = 3;   // results one input beat can cause
    localparam int FIFO_DEPTH  = 4;   // result queue entries
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2,
        PH_SPARE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } t_item;

    typedef struct packed {
        logic [RCNT_W-1:0]           count;
        t_item [MAX_RESULTS-1:0]     items;
    } t_result_set;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/urldec_if.sv @@
// Valid/ready channel interfaces for the URL percent decoder.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface urldec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urldec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_byte, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_error,
                    output ready);
endinterface
`default_nettype wire

@@ hdl/urldec_core.sv @@
// Decode step: escape state and the 0..3 results caused by one input beat.
// Depends on urldec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urldec_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic [7:0]              i_byte,
    input  wire logic                    i_last,
    output urldec_pkg::t_result_set      o_res
);
    import urldec_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    logic       r_drop,  n_drop;

    logic [4:0] hv, hh;
    logic [7:0] dec;

    // byte with no escape pending: {emit, item, starts escape}
    function automatic logic [11:0] plain(input logic [7:0] b, input logic last);
        logic [11:0] r;
        if (b == CH_PERCENT) begin
            r = last ? {1'b1, CH_PERCENT, 1'b1, 1'b0, 1'b0} : {1'b0, 8'h00, 3'b001};
        end else if (b == CH_PLUS) begin
            r = {1'b1, CH_SPACE, last, 1'b0, 1'b0};
        end else begin
            r = {1'b1, b, last, 1'b0, 1'b0};
        end
        return r;
    endfunction

    logic [11:0] pl;

    always_comb begin
        hv  = hex_decode(i_byte);
        hh  = hex_decode(r_held);
        dec = {hh[3:0], hv[3:0]};
        pl  = plain(i_byte, i_last);

        o_res   = '0;
        n_phase = r_phase;
        n_held  = r_held;
        n_drop  = r_drop;

        if (r_drop) begin
            n_drop  = !i_last;
            n_phase = PH_NONE;
        end else begin
            case (r_phase)
                PH_PCT: begin
                    if (hv[4]) begin
                        if (i_last) begin
                            o_res.items[0] = '{CH_PERCENT, 1'b0, 1'b0};
                            o_res.items[1] = '{i_byte, 1'b1, 1'b0};
                            o_res.count    = RCNT_W'(2);
                            n_phase        = PH_NONE;
                        end else begin
                            n_held  = i_byte;
                            n_phase = PH_DIGIT;
                        end
                    end else begin
                        o_res.items[0] = '{CH_PERCENT, 1'b0, 1'b0};
                        o_res.items[1] = pl[10:1];
                        o_res.count    = pl[11] ? RCNT_W'(2) : RCNT_W'(1);
                        n_phase        = pl[0] ? PH_PCT : PH_NONE;
                    end
                end
                PH_DIGIT: begin
                    if (hv[4] && hh[4]) begin
                        n_phase = PH_NONE;
                        o_res.count = RCNT_W'(1);
                        if (dec == CH_NUL) begin
                            // rejected string: error beat, drop the rest
                            o_res.items[0] = '{CH_NUL, 1'b1, 1'b1};
                            n_drop         = !i_last;
                        end else begin
                            o_res.items[0] = '{dec, i_last, 1'b0};
                        end
                    end else begin
                        o_res.items[0] = '{CH_PERCENT, 1'b0, 1'b0};
                        o_res.items[1] = '{r_held, 1'b0, 1'b0};
                        o_res.items[2] = pl[10:1];
                        o_res.count    = pl[11] ? RCNT_W'(3) : RCNT_W'(2);
                        n_phase        = pl[0] ? PH_PCT : PH_NONE;
                    end
                end
                default: begin
                    o_res.items[0] = pl[10:1];
                    o_res.count    = pl[11] ? RCNT_W'(1) : RCNT_W'(0);
                    n_phase        = pl[0] ? PH_PCT : PH_NONE;
                end
            endcase
        end

        if (!i_take) begin
            o_res.count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NONE;
            r_held  <= 8'h00;
            r_drop  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_drop  <= n_drop;
        end
    end

endmodule
`default_nettype wire

@@ hdl/url_percent_decoder_unit.sv @@
// Top level of the URL percent decoder: decode step plus result queue.
// Depends on urldec_pkg, urldec_in_if, urldec_out_if, urldec_core.
//
// Usage:
//   i_in carries the raw bytes of encoded strings, one byte per beat, with
//   in_last set on the final byte of each string. o_out carries decoded
//   bytes; out_last marks the final result of a string and out_error marks
//   the single result left by a string whose escape decoded to a zero byte.
//   Results are written into the result queue and offered on o_out from
//   there (a "%" or first hex digit not on a last beat causes no result).
//   Throughput: one input beat per cycle while each beat yields at most one
//   result and o_out is ready. A beat that flushes a broken escape yields
//   one to three results; the four-entry result queue then drains at one
//   beat per cycle; i_in is held off while fewer than three entries are free.
//   A stall on o_out fills the queue; i_in keeps taking beats while the
//   queue has room for the worst case, so a waiting result does not block
//   the next input beat.
//   Reset (synchronous, active low) empties the queue and clears the
//   escape and drop state.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    urldec_in_if.sink   i_in,
    urldec_out_if.source o_out
);
    import urldec_pkg::*;

    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - MAX_RESULTS);

    t_item             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    t_result_set       res;
    logic              take;
    logic              pop;

    // accept only when the worst case of one beat still fits
    assign i_in.ready = (r_count <= ROOM_LIMIT);
    assign take       = i_in.valid && i_in.ready;

    urldec_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .o_res   (res)
    );

    assign o_out.valid     = (r_count != '0);
    assign o_out.out_byte  = r_mem[r_rd].data;
    assign o_out.out_last  = r_mem[r_rd].last;
    assign o_out.out_error = r_mem[r_rd].error;
    assign pop             = o_out.valid && o_out.ready;

    // queue storage: up to MAX_RESULTS consecutive slots per beat
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RCNT_W'(k) < res.count) begin
                r_mem[PTR_W'(r_wr + PTR_W'(k))] <= res.items[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= PTR_W'(r_wr + PTR_W'(res.count));
            if (pop) begin
                r_rd <= PTR_W'(r_rd + PTR_W'(1));
            end
            r_count <= CNT_W'(r_count + CNT_W'(res.count) - CNT_W'(pop));
        end
    end

endmodule
`default_nettype wire
